/* rtl/eqsb_pkg.sv */
// shared types and constants for the error queue and status byte block
package eqsb_pkg;

   typedef enum logic [1:0] {
      KIND_SAVE    = 2'd0,
      KIND_READ    = 2'd1,
      KIND_RESET   = 2'd2,
      KIND_REFRESH = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_SRE     = 2'd0,
      CSR_ESE     = 2'd1,
      CSR_ESR     = 2'd2,
      CSR_LOWBITS = 2'd3
   } csr_index_type;

   localparam int unsigned CODE_W   = 6;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LOW_W    = 3;
   localparam int unsigned RSP_W    = 16;

   localparam logic [CODE_W-1:0] OVERFLOW_CODE    = 6'd39;
   localparam logic [BYTE_W-1:0] KEEP_LOW_MASK    = 8'h07;
   localparam logic [BYTE_W-1:0] MSS_EXCLUDE_MASK = 8'hBF;
   localparam logic [BYTE_W-1:0] MSS_BIT          = 8'h40;
   localparam logic [BYTE_W-1:0] ESB_BIT          = 8'h20;
   localparam logic [BYTE_W-1:0] MAV_BIT          = 8'h10;

   // per-cell control: pop shifts the row toward the head, load takes the new code
   typedef struct packed {
      logic pop;
      logic load;
   } cell_ctrl_type;

endpackage

/* rtl/eqsb_cell.sv */
// one queue cell: holds one error code, takes its neighbor's code on a pop
module eqsb_cell (
   input  logic                                clock,
   input  eqsb_pkg::cell_ctrl_type             ctrl,
   input  logic [eqsb_pkg::CODE_W-1:0]         load_code,
   input  logic [eqsb_pkg::CODE_W-1:0]         neighbor_code,
   output logic [eqsb_pkg::CODE_W-1:0]         code_out
);
   import eqsb_pkg::*;

   logic [CODE_W-1:0] code_ff;
   logic [CODE_W-1:0] code_in;

   always_comb begin
      code_in = code_ff;
      if (ctrl.load) begin
         code_in = load_code;
      end else if (ctrl.pop) begin
         code_in = neighbor_code;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code_out = code_ff;

endmodule

/* rtl/error_queue_status_byte_top.sv */
// error queue with status byte: a row of shifting code cells plus status logic
// latency: a result beat is registered and shown in the cycle after its request beat is accepted
// throughput: one request per cycle while the result side is ready; the cell row shifts on a read, loads on a save
// reset: synchronous, clears the fill count, result valid and config registers
// cell contents are not reset; a cell is only read after a save has loaded it
module error_queue_status_byte_top #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // error_code[5:0], zero pad
   input  logic [1:0]                     req_tuser,   // kind[1:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [eqsb_pkg::RSP_W-1:0]     rsp_tdata,   // read_code[5:0], status_byte[13:6],
                                                       // queue_empty[14], zero pad
   input  logic                           csr_wen,
   input  logic [1:0]                     csr_addr,
   input  logic [eqsb_pkg::BYTE_W-1:0]    csr_wdata
);
   import eqsb_pkg::*;

   localparam int unsigned NCELLS = QUEUE_DEPTH - 1;
   localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH);

   logic [BYTE_W-1:0] sre_ff;
   logic [BYTE_W-1:0] ese_ff;
   logic [BYTE_W-1:0] esr_ff;
   logic [LOW_W-1:0]  low_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic [RSP_W-1:0]  rsp_data_in;

   logic              req_accept;
   kind_type          kind;
   logic [CODE_W-1:0] req_code;
   logic              full;
   logic              do_load;
   logic              do_pop;
   logic [CNT_W-1:0]  load_slot;
   logic [CODE_W-1:0] load_code;
   logic [CODE_W-1:0] read_code;
   logic [BYTE_W-1:0] status_base;
   logic [BYTE_W-1:0] status_byte;

   logic [CODE_W-1:0] cell_code [NCELLS];

   assign req_accept = req_tvalid & req_tready;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign kind       = kind_type'(req_tuser);
   assign req_code   = req_tdata[CODE_W-1:0];
   assign full       = (count_ff == CNT_W'(NCELLS));

   always_comb begin
      count_in  = count_ff;
      do_load   = 1'b0;
      do_pop    = 1'b0;
      load_slot = count_ff;
      load_code = req_code;
      read_code = '0;
      if (req_accept) begin
         unique case (kind)
            KIND_SAVE: begin
               do_load = 1'b1;
               if (full) begin
                  // overflow replaces the newest entry
                  load_slot = count_ff - CNT_W'(1);
                  load_code = OVERFLOW_CODE;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_READ: begin
               if (count_ff != '0) begin
                  do_pop    = 1'b1;
                  read_code = cell_code[0];
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            KIND_RESET: begin
               count_in = '0;
            end
            KIND_REFRESH: begin
               count_in = count_ff;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // cell row, oldest entry in cell 0
   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [CODE_W-1:0] neighbor;

      assign ctrl.pop  = do_pop;
      assign ctrl.load = do_load & (load_slot == CNT_W'(i));
      if (i + 1 < NCELLS) begin : g_mid
         assign neighbor = cell_code[i+1];
      end else begin : g_end
         assign neighbor = '0;
      end

      eqsb_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .load_code     (load_code),
         .neighbor_code (neighbor),
         .code_out      (cell_code[i])
      );
   end

   always_comb begin
      status_base = {5'b0, low_ff} & KEEP_LOW_MASK;
      if ((esr_ff & ese_ff) != '0) begin
         status_base = status_base | ESB_BIT;
      end
      if (count_in != '0) begin
         status_base = status_base | MAV_BIT;
      end
      status_byte = status_base;
      if ((status_base & sre_ff & MSS_EXCLUDE_MASK) != '0) begin
         status_byte = status_base | MSS_BIT;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, (count_in == '0), status_byte, read_code};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sre_ff       <= '0;
         ese_ff       <= '0;
         esr_ff       <= '0;
         low_ff       <= '0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_index_type'(csr_addr))
               CSR_SRE:     sre_ff <= csr_wdata;
               CSR_ESE:     ese_ff <= csr_wdata;
               CSR_ESR:     esr_ff <= csr_wdata;
               CSR_LOWBITS: low_ff <= csr_wdata[LOW_W-1:0];
               default:     low_ff <= low_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NCELLS))
      else $error("fill count beyond cell row");

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no result beat");

   a_mav_matches_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[CODE_W+4] == ~rsp_data_ff[CODE_W+BYTE_W]))
      else $error("status MAV disagrees with queue_empty");

   a_empty_no_code: assert property (@(posedge clock) disable iff (reset)
      (req_accept && count_ff == '0) |=> (rsp_data_ff[CODE_W-1:0] == '0))
      else $error("read from empty queue returned a code");
`endif

endmodule

/* verif/tb_error_queue_status_byte_top.sv */
// testbench for the error queue and status byte block: ring predictor with beat checking
module tb_error_queue_status_byte_top;
   timeunit 1ns;
   timeprecision 1ps;
   import eqsb_pkg::*;

   localparam int unsigned DEPTH = 16;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned PHASES = 8;
   localparam int unsigned PHASE_ITEMS = 138;

   // predicts one result beat per request beat and checks them in order
   class eqsb_scoreboard;
      typedef struct {
         logic [CODE_W-1:0] read_code;
         logic [BYTE_W-1:0] status;
         logic              empty;
      } queue_result_type;

      logic [CODE_W-1:0] code_ring [DEPTH];
      logic [PTR_W-1:0]  wr_ptr;
      logic [PTR_W-1:0]  rd_ptr;
      logic [BYTE_W-1:0] sre;
      logic [BYTE_W-1:0] ese;
      logic [BYTE_W-1:0] esr;
      logic [LOW_W-1:0]  low_bits;
      queue_result_type  awaited [$];
      int unsigned       errors;

      function new();
         foreach (code_ring[i]) code_ring[i] = '0;
         wr_ptr   = '0;
         rd_ptr   = '0;
         sre      = '0;
         ese      = '0;
         esr      = '0;
         low_bits = '0;
         errors   = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [BYTE_W-1:0] value);
         case (idx)
            CSR_SRE:     sre = value;
            CSR_ESE:     ese = value;
            CSR_ESR:     esr = value;
            CSR_LOWBITS: low_bits = value[LOW_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
         return PTR_W'((p + 1) % DEPTH);
      endfunction

      function logic [BYTE_W-1:0] status_byte();
         logic [BYTE_W-1:0] sb;
         sb = BYTE_W'(low_bits) & KEEP_LOW_MASK;
         if ((esr & ese) != '0) sb |= ESB_BIT;
         if (wr_ptr != rd_ptr) sb |= MAV_BIT;
         // mss summarizes every other bit under the enable mask
         if ((sb & sre & MSS_EXCLUDE_MASK) != '0) sb |= MSS_BIT;
         return sb;
      endfunction

      function void note_request(kind_type kind, logic [CODE_W-1:0] code);
         queue_result_type r;
         r.read_code = '0;
         case (kind)
            KIND_SAVE: begin
               if (ring_next(wr_ptr) != rd_ptr) begin
                  wr_ptr = ring_next(wr_ptr);
                  code_ring[wr_ptr] = code;
               end else begin
                  // full ring: newest entry becomes the overflow code
                  code_ring[wr_ptr] = OVERFLOW_CODE;
               end
            end
            KIND_READ: begin
               if (wr_ptr != rd_ptr) begin
                  rd_ptr = ring_next(rd_ptr);
                  r.read_code = code_ring[rd_ptr];
               end
            end
            KIND_RESET: begin
               wr_ptr = '0;
               rd_ptr = '0;
            end
            default: ;
         endcase
         r.status = status_byte();
         r.empty  = (wr_ptr == rd_ptr);
         awaited.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch at %0t ns: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic [RSP_W-1:0] beat);
         queue_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("result beat %h with nothing expected", beat));
            return;
         end
         want = awaited.pop_front();
         if (beat[5:0] != want.read_code)
            report($sformatf("read_code %0d, expected %0d", beat[5:0], want.read_code));
         if (beat[13:6] != want.status)
            report($sformatf("status_byte %h, expected %h", beat[13:6], want.status));
         if (beat[14] != want.empty)
            report($sformatf("queue_empty %b, expected %b", beat[14], want.empty));
      endtask

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata   = '0;
   logic [1:0]        req_tuser   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_wen     = 1'b0;
   logic [1:0]        csr_addr    = '0;
   logic [BYTE_W-1:0] csr_wdata   = '0;

   eqsb_scoreboard sb = new();
   int             burst_left = 0;
   int             stall_left = 0;
   int             stall_mode = 0;
   logic [15:0]    stall_pat  = '0;

   error_queue_status_byte_top #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver stalls: stretches of always ready, random patterns and mostly stalled
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(8, 80);
         stall_mode = $urandom_range(0, 3);
         stall_pat  = 16'($urandom);
      end
      stall_left--;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         3:       rsp_tready <= stall_pat[0] & stall_pat[5];
         default: rsp_tready <= stall_pat[0];
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(kind_type'(req_tuser), req_tdata[CODE_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
      end
   end

   task send_item(input kind_type kind, input logic [CODE_W-1:0] code);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, code};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop sending and let every outstanding beat come back
   task wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task write_csr(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task load_settings(input logic [BYTE_W-1:0] sre_v, input logic [BYTE_W-1:0] ese_v,
                      input logic [BYTE_W-1:0] esr_v, input logic [BYTE_W-1:0] low_v);
      write_csr(CSR_SRE, sre_v);
      write_csr(CSR_ESE, ese_v);
      write_csr(CSR_ESR, esr_v);
      write_csr(CSR_LOWBITS, low_v);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int       save_pct;
      int       pick;
      kind_type kind;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty read, code extremes, fill to full, overflow, queue reset
      send_item(KIND_REFRESH, 6'd0);
      send_item(KIND_READ, 6'd63);
      send_item(KIND_SAVE, 6'd0);
      send_item(KIND_SAVE, 6'd63);
      send_item(KIND_SAVE, 6'd47);
      send_item(KIND_SAVE, 6'd48);
      for (int i = 0; i < DEPTH - 5; i++) send_item(KIND_SAVE, CODE_W'(i * 5 + 1));
      send_item(KIND_SAVE, 6'd21);
      send_item(KIND_SAVE, 6'd42);
      send_item(KIND_READ, 6'd0);
      send_item(KIND_READ, 6'd0);
      send_item(KIND_RESET, 6'd63);
      send_item(KIND_READ, 6'd0);
      send_item(KIND_REFRESH, 6'd63);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            1: load_settings(8'h00, 8'h00, 8'h00, 8'h00);
            2: load_settings(MSS_BIT, 8'($urandom), 8'($urandom), 8'($urandom));
            default: load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         // save share per phase sets whether the ring runs full or mostly empty
         save_pct = $urandom_range(20, 75);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick >= 97)
               kind = KIND_RESET;
            else if (pick >= 92)
               kind = KIND_REFRESH;
            else if (pick < save_pct)
               kind = KIND_SAVE;
            else
               kind = KIND_READ;
            send_item(kind, CODE_W'($urandom_range(0, 63)));
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

endmodule
